/* hw/rtl/edrw_pkg.sv */
// edrw_pkg: shared types, codes and constants for the recovery watchdog.
// Used by the core, the slot RAM, the remainder unit and the checker.
`default_nettype none
package edrw_pkg;

	localparam int unsigned NUM_SLOTS_DEF = 5;

	localparam int unsigned FN_W      = 22;
	localparam int unsigned SLOT_W    = 3;
	localparam int unsigned FUNC_W    = 3;
	localparam int unsigned DIR_W     = 2;
	localparam int unsigned SUB_W     = 2;
	localparam int unsigned PER_W     = 8;
	localparam int unsigned DL_W      = 16;
	localparam int unsigned CNT8_W    = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DW    = 16;

	// frame arithmetic
	localparam logic [FN_W-1:0] FN_MOD     = 22'd2715648;
	localparam logic [FN_W-1:0] FN_HALF    = 22'd1357824;
	localparam logic [FN_W-1:0] FN_INVALID = 22'h3FFFFF;

	// commands
	localparam logic [FUNC_W-1:0] FN_TICK      = 3'd0;
	localparam logic [FUNC_W-1:0] FN_REG_SLOT  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_DEREG     = 3'd2;
	localparam logic [FUNC_W-1:0] FN_REG_REL   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_RESET     = 3'd4;
	localparam logic [FUNC_W-1:0] FN_SET_SUB   = 3'd5;

	// slots
	localparam logic [SLOT_W-1:0] SLOT_UL_CONN = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_DL_CONN = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_LOW_TS  = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_UL_REL  = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_DL_REL  = 3'd4;

	// substates
	localparam logic [SUB_W-1:0] SUB_NULL     = 2'd0;
	localparam logic [SUB_W-1:0] SUB_CHECK    = 2'd1;
	localparam logic [SUB_W-1:0] SUB_IND_SENT = 2'd2;
	localparam logic [SUB_W-1:0] SUB_STARTED  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADLINE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EV_TRIG      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MM_TRIG      = 2'd3;

	localparam logic [PER_W-1:0]  CHECK_PERIOD_RST = 8'd52;
	localparam logic [DL_W-1:0]   DEADLINE_RST     = 16'd100;
	localparam logic [CNT8_W-1:0] EV_TRIG_RST      = 8'd3;
	localparam logic [CNT8_W-1:0] MM_TRIG_RST      = 8'd3;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [FN_W-1:0]   frame_number;
		logic [SLOT_W-1:0] event_slot;
		logic [FN_W-1:0]   start_frame;
		logic [DIR_W-1:0]  release_dir;
		logic              blocked_mode;
		logic              state_mismatch;
		logic [SUB_W-1:0]  new_substate;
	} cmd_t;

	typedef struct packed {
		logic             recovery_indication;
		logic [SUB_W-1:0] current_substate;
	} rsp_t;

	typedef struct packed {
		logic [FN_W-1:0]   start_frame;
		logic [FN_W-1:0]   reg_frame;
		logic [CNT8_W-1:0] overdue_cnt;
	} slot_entry_t;

	typedef struct packed {
		logic done;
		logic zero;
	} rem_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/edrw_slot_ram.sv */
// edrw_slot_ram: per-slot frame stamps and overdue counts.
// One write port, one read port, registered read data. Depends on edrw_pkg.
`default_nettype none
module edrw_slot_ram
	import edrw_pkg::*;
#(
	parameter int unsigned DEPTH = NUM_SLOTS_DEF,
	parameter int unsigned AW    = $clog2(NUM_SLOTS_DEF)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  slot_entry_t        wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output slot_entry_t        rdata
);

	slot_entry_t mem_q [DEPTH];
	slot_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* hw/rtl/edrw_rem_unit.sv */
// edrw_rem_unit: bit-serial remainder of a frame number by the check period.
// One dividend bit per cycle. Depends on edrw_pkg.
`default_nettype none
module edrw_rem_unit
	import edrw_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [FN_W-1:0]  dividend,
	input  wire logic [PER_W-1:0] divisor,
	output rem_sts_t              sts
);

	localparam int unsigned ITER_W = $clog2(FN_W + 1);

	logic [FN_W-1:0]   dv_q;
	logic [PER_W-1:0]  rem_q;
	logic [PER_W-1:0]  div_q;
	logic [ITER_W-1:0] iter_q;
	logic              run_q;
	logic              done_q;
	logic [PER_W:0]    trial;
	logic [PER_W-1:0]  rem_nxt;

	// restoring step: shift in next bit, subtract divisor if it fits
	always_comb begin
		trial = {rem_q, dv_q[FN_W-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_nxt = PER_W'(trial - {1'b0, div_q});
		end else begin
			rem_nxt = trial[PER_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_q   <= '0;
			rem_q  <= '0;
			div_q  <= '0;
			iter_q <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dv_q   <= dividend;
				div_q  <= divisor;
				rem_q  <= '0;
				iter_q <= ITER_W'(FN_W);
				run_q  <= 1'b1;
			end else if (run_q) begin
				dv_q   <= {dv_q[FN_W-2:0], 1'b0};
				rem_q  <= rem_nxt;
				iter_q <= iter_q - 1'b1;
				if (iter_q == ITER_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sts.done = done_q;
	assign sts.zero = (rem_q == '0);

endmodule
`default_nettype wire

/* hw/rtl/event_deadline_recovery_watchdog_core.sv */
// Recovery watchdog core: five frame-stamped event slots with overdue counting.
// Other commands answer directly; a registration reads, then writes the slot RAM;
// a tick in null or check runs the remainder, then the slot sweep on a check frame.
// Throughput: one command in flight; set by the serial remainder and the RAM sweep.
// Reset (arst_n low): config to defaults, all slots invalid, substate null.
// Slot RAM needs no clearing pass; per-slot valid flops mask stale entries.
`default_nettype none
module event_deadline_recovery_watchdog_core
	import edrw_pkg::*;
#(
	parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_valid,
	output logic                      cmd_ready,
	input  cmd_t                      cmd,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output rsp_t                      rsp,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_DW-1:0]    cfg_wdata
);

	localparam int unsigned SLOT_AW = $clog2(NUM_SLOTS);
	localparam int unsigned ISS_W   = $clog2(NUM_SLOTS + 1);
	localparam logic [SLOT_W-1:0] NUM_SLOTS_C = SLOT_W'(NUM_SLOTS);
	localparam logic [ISS_W-1:0]  NUM_SLOTS_I = ISS_W'(NUM_SLOTS);

	// half-range later-than test on a signed frame difference
	localparam logic signed [FN_W:0] HALF_S     = $signed({1'b0, FN_HALF});
	localparam logic signed [FN_W:0] NEG_HALF_S = -$signed({1'b0, FN_HALF});

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_REG_RD = 7'b0000010,
		ST_REG_WR = 7'b0000100,
		ST_DIV    = 7'b0001000,
		ST_CHK    = 7'b0010000,
		ST_FIN    = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration
	logic [PER_W-1:0]  period_q;
	logic [DL_W-1:0]   deadline_q;
	logic [CNT8_W-1:0] ev_trig_q;
	logic [CNT8_W-1:0] mm_trig_q;

	// scalar state
	logic [NUM_SLOTS-1:0] valid_q;
	logic [CNT8_W-1:0]    mm_cnt_q;
	logic [SUB_W-1:0]     sub_q;

	// current command
	logic [FN_W-1:0]    fn_q;
	logic [FN_W-1:0]    start_q;
	logic [SLOT_AW-1:0] cur_q;
	logic               dl_pend_q;
	logic               mismatch_q;
	logic               ind_q;
	logic               trig_q;

	// check sweep pipeline
	logic [ISS_W-1:0]   issue_q;
	logic               chk_vld_s1;
	logic [SLOT_AW-1:0] chk_slot_s1;
	logic               chk_pv_s2;
	logic               chk_act_s2;
	logic [SLOT_AW-1:0] slot_s2;
	logic [FN_W-1:0]    due_s2;
	logic [CNT8_W-1:0]  cnt_s2;
	logic [FN_W-1:0]    start_s2;
	logic [FN_W-1:0]    reg_s2;

	// output register
	logic rsp_valid_q;
	rsp_t rsp_q;

	// RAM ports
	logic               ram_re;
	logic [SLOT_AW-1:0] ram_raddr;
	logic               ram_we;
	logic [SLOT_AW-1:0] ram_waddr;
	slot_entry_t        ram_wdata;
	slot_entry_t        ram_rdata;

	// remainder unit
	logic             rem_start;
	logic [PER_W-1:0] per_eff;
	rem_sts_t         rem_sts;

	logic [FN_W-1:0]          fn_red;
	logic                     slot_ok;
	logic [SLOT_AW-1:0]       cmd_slot;
	logic                     chk_re;
	logic [FN_W-1:0]          base_s1;
	logic [FN_W:0]            sum_s1;
	logic [FN_W-1:0]          due_s1;
	logic signed [FN_W:0]     diff_s2;
	logic                     overdue_s2;
	logic                     hit_s2;

	assign cmd_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// frame number reduced mod FN_MOD: one conditional subtract covers 22 bits
	assign fn_red   = (cmd.frame_number >= FN_MOD) ? (cmd.frame_number - FN_MOD)
		: cmd.frame_number;
	assign slot_ok  = (cmd.event_slot < NUM_SLOTS_C);
	assign cmd_slot = cmd.event_slot[SLOT_AW-1:0];

	// period of zero acts as one
	assign per_eff   = (period_q == '0) ? PER_W'(1) : period_q;
	assign rem_start = (state_q == ST_IDLE) && cmd_valid && (cmd.func == FN_TICK)
		&& ((sub_q == SUB_NULL) || (sub_q == SUB_CHECK));

	edrw_rem_unit u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (fn_red),
		.divisor  (per_eff),
		.sts      (rem_sts)
	);

	// stage 1 -> 2: deadline of the slot just read
	// connect and low-ts slots use the start frame, release slots the registration frame
	always_comb begin
		base_s1 = (chk_slot_s1 < SLOT_AW'(SLOT_UL_REL)) ? ram_rdata.start_frame
			: ram_rdata.reg_frame;
		// base + deadline stays below 2*FN_MOD, so one subtract reduces it
		sum_s1 = {1'b0, base_s1} + (FN_W + 1)'(deadline_q);
		if (sum_s1 >= {1'b0, FN_MOD}) begin
			due_s1 = FN_W'(sum_s1 - {1'b0, FN_MOD});
		end else begin
			due_s1 = sum_s1[FN_W-1:0];
		end
	end

	// stage 2: overdue test and count update
	// (fn - due) mod FN_MOD in (0, HALF) <=> diff in (0, HALF) or diff < -HALF
	always_comb begin
		diff_s2    = $signed({1'b0, fn_q}) - $signed({1'b0, due_s2});
		overdue_s2 = ((diff_s2 > 0) && (diff_s2 < HALF_S)) || (diff_s2 < NEG_HALF_S);
		hit_s2     = (cnt_s2 == ev_trig_q);
	end

	assign chk_re = (state_q == ST_CHK) && (issue_q < NUM_SLOTS_I);

	// RAM access steering
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = cur_q;
		ram_we    = 1'b0;
		ram_waddr = cur_q;
		// registration keeps the count of a live slot, invalid slots hold zero
		ram_wdata.start_frame = start_q;
		ram_wdata.reg_frame   = fn_q;
		ram_wdata.overdue_cnt = valid_q[cur_q] ? ram_rdata.overdue_cnt : '0;
		case (state_q)
			ST_REG_RD: begin
				ram_re = 1'b1;
			end
			ST_REG_WR: begin
				ram_we = 1'b1;
			end
			ST_CHK: begin
				ram_re    = chk_re;
				ram_raddr = issue_q[SLOT_AW-1:0];
				// write-back of a bumped count; reads target later slots only
				if (chk_act_s2 && overdue_s2 && !hit_s2) begin
					ram_we    = 1'b1;
					ram_waddr = slot_s2;
					ram_wdata.start_frame = start_s2;
					ram_wdata.reg_frame   = reg_s2;
					ram_wdata.overdue_cnt = cnt_s2 + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	edrw_slot_ram #(
		.DEPTH (NUM_SLOTS),
		.AW    (SLOT_AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sweep pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_vld_s1  <= 1'b0;
			chk_slot_s1 <= '0;
			chk_pv_s2   <= 1'b0;
			chk_act_s2  <= 1'b0;
		end else begin
			chk_vld_s1  <= chk_re;
			chk_slot_s1 <= issue_q[SLOT_AW-1:0];
			chk_pv_s2   <= chk_vld_s1;
			chk_act_s2  <= chk_vld_s1 && valid_q[chk_slot_s1];
		end
	end

	always_ff @(posedge clk) begin
		slot_s2  <= chk_slot_s1;
		due_s2   <= due_s1;
		cnt_s2   <= ram_rdata.overdue_cnt;
		start_s2 <= ram_rdata.start_frame;
		reg_s2   <= ram_rdata.reg_frame;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			period_q    <= CHECK_PERIOD_RST;
			deadline_q  <= DEADLINE_RST;
			ev_trig_q   <= EV_TRIG_RST;
			mm_trig_q   <= MM_TRIG_RST;
			valid_q     <= '0;
			mm_cnt_q    <= '0;
			sub_q       <= SUB_NULL;
			fn_q        <= '0;
			start_q     <= '0;
			cur_q       <= '0;
			dl_pend_q   <= 1'b0;
			mismatch_q  <= 1'b0;
			ind_q       <= 1'b0;
			trig_q      <= 1'b0;
			issue_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_CHECK_PERIOD: period_q   <= cfg_wdata[PER_W-1:0];
					CFG_DEADLINE:     deadline_q <= cfg_wdata[DL_W-1:0];
					CFG_EV_TRIG:      ev_trig_q  <= cfg_wdata[CNT8_W-1:0];
					CFG_MM_TRIG:      mm_trig_q  <= cfg_wdata[CNT8_W-1:0];
					default: begin
					end
				endcase
			end

			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						fn_q       <= fn_red;
						start_q    <= cmd.start_frame;
						mismatch_q <= cmd.state_mismatch;
						ind_q      <= 1'b0;
						trig_q     <= 1'b0;
						dl_pend_q  <= 1'b0;
						state_q    <= ST_DONE;
						case (cmd.func)
							FN_TICK: begin
								// null moves to check before the check test
								if ((sub_q == SUB_NULL) || (sub_q == SUB_CHECK)) begin
									sub_q   <= SUB_CHECK;
									state_q <= ST_DIV;
								end
							end
							FN_REG_SLOT: begin
								if (!cmd.blocked_mode && slot_ok) begin
									cur_q   <= cmd_slot;
									state_q <= ST_REG_RD;
								end
							end
							FN_DEREG: begin
								// invalid entries read as cleared
								if (!cmd.blocked_mode && slot_ok) begin
									valid_q[cmd_slot] <= 1'b0;
								end
							end
							FN_REG_REL: begin
								if (!cmd.blocked_mode && (cmd.release_dir != '0)) begin
									start_q   <= FN_INVALID;
									cur_q     <= cmd.release_dir[0] ? SLOT_AW'(SLOT_UL_REL)
										: SLOT_AW'(SLOT_DL_REL);
									dl_pend_q <= cmd.release_dir[0] & cmd.release_dir[1];
									state_q   <= ST_REG_RD;
								end
							end
							FN_RESET: begin
								valid_q  <= '0;
								mm_cnt_q <= '0;
								sub_q    <= SUB_NULL;
							end
							FN_SET_SUB: begin
								sub_q <= cmd.new_substate;
							end
							default: begin
							end
						endcase
					end
				end
				ST_REG_RD: begin
					state_q <= ST_REG_WR;
				end
				ST_REG_WR: begin
					valid_q[cur_q] <= 1'b1;
					// a release registration drops the matching connect slot
					if (cur_q == SLOT_AW'(SLOT_UL_REL)) begin
						valid_q[SLOT_AW'(SLOT_UL_CONN)] <= 1'b0;
					end
					if (cur_q == SLOT_AW'(SLOT_DL_REL)) begin
						valid_q[SLOT_AW'(SLOT_DL_CONN)] <= 1'b0;
					end
					if (dl_pend_q) begin
						cur_q     <= SLOT_AW'(SLOT_DL_REL);
						dl_pend_q <= 1'b0;
						state_q   <= ST_REG_RD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					if (rem_sts.done) begin
						issue_q <= '0;
						state_q <= rem_sts.zero ? ST_CHK : ST_DONE;
					end
				end
				ST_CHK: begin
					if (chk_re) begin
						issue_q <= issue_q + 1'b1;
					end
					if (chk_act_s2 && overdue_s2 && hit_s2) begin
						trig_q <= 1'b1;
					end
					// sweep drained once nothing is issued or in flight
					if (!chk_re && !chk_vld_s1 && !chk_pv_s2) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!trig_q && mismatch_q) begin
						if (mm_cnt_q == mm_trig_q) begin
							ind_q <= 1'b1;
							sub_q <= SUB_IND_SENT;
						end else begin
							mm_cnt_q <= mm_cnt_q + 1'b1;
						end
					end else begin
						mm_cnt_q <= '0;
						if (trig_q) begin
							ind_q <= 1'b1;
							sub_q <= SUB_IND_SENT;
						end
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hand off once the output register is free
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q                 <= 1'b1;
						rsp_q.recovery_indication   <= ind_q;
						rsp_q.current_substate      <= sub_q;
						state_q                     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/edrw_checker.sv */
// edrw_checker: port-level assertions for the recovery watchdog core.
// Bound to event_deadline_recovery_watchdog_core. Depends on edrw_pkg.
`default_nettype none
module edrw_checker
	import edrw_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 cmd_valid,
	input wire logic                 cmd_ready,
	input cmd_t                      cmd,
	input wire logic                 rsp_valid,
	input wire logic                 rsp_ready,
	input rsp_t                      rsp,
	input wire logic                 cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_idx,
	input wire logic [CFG_DW-1:0]    cfg_wdata
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp dropped or changed while stalled");

	// an indication always comes with the indication-sent substate
	a_ind_sub: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.recovery_indication |-> rsp.current_substate == SUB_IND_SENT)
		else $error("indication without ind-sent substate");

	// one command at a time: ready drops after each command transfer
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("second command taken while busy");

	// a command transfer is never directly followed by a rising result
	a_rsp_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(cmd_valid && cmd_ready))
		else $error("result raised in the cycle right after a command transfer");

endmodule

bind event_deadline_recovery_watchdog_core edrw_checker u_edrw_checker (.*);
`default_nettype wire

/* verif/tb_event_deadline_recovery_watchdog_core.sv */
`timescale 1ns / 100ps
// Self-checking bench for event_deadline_recovery_watchdog_core: directed and random
// command streams, a cycle-free watchdog predictor and an in-order response scoreboard.
// Depends on edrw_pkg and the core RTL only.
module tb_event_deadline_recovery_watchdog_core;
	import edrw_pkg::*;

	// frame arithmetic as plain integers
	localparam int unsigned FRAMES      = FN_MOD;
	localparam int unsigned HALF_FRAMES = FN_HALF;
	localparam int unsigned FN_SPAN     = 1 << FN_W;

	// codes the package leaves unnamed
	localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;
	localparam logic [SLOT_W-1:0] SLOT_BAD_LO  = 3'd5;
	localparam logic [SLOT_W-1:0] SLOT_BAD_HI  = 3'd7;
	localparam logic [DIR_W-1:0]  REL_NONE     = 2'd0;
	localparam logic [DIR_W-1:0]  REL_UL       = 2'd1;
	localparam logic [DIR_W-1:0]  REL_DL       = 2'd2;
	localparam logic [DIR_W-1:0]  REL_BOTH     = 2'd3;

	// leave margin for a checking tick to finish before touching registers
	localparam int unsigned SETTLE_CYCLES = 48;
	localparam int unsigned MAX_REPORTS   = 20;
	localparam int          NUM_PHASES    = 8;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_ready;
	cmd_t                 cmd       = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx   = CFG_CHECK_PERIOD;
	logic [CFG_DW-1:0]    cfg_wdata = '0;

	event_deadline_recovery_watchdog_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Watchdog predictor: own copy of registers and slot state
	// ------------------------------------------------------------------
	logic [PER_W-1:0]  wd_period   = CHECK_PERIOD_RST;
	logic [DL_W-1:0]   wd_deadline = DEADLINE_RST;
	logic [CNT8_W-1:0] wd_ev_trig  = EV_TRIG_RST;
	logic [CNT8_W-1:0] wd_mm_trig  = MM_TRIG_RST;

	logic              wd_valid  [NUM_SLOTS_DEF];
	logic [FN_W-1:0]   wd_start  [NUM_SLOTS_DEF];
	logic [FN_W-1:0]   wd_regfn  [NUM_SLOTS_DEF];
	logic [CNT8_W-1:0] wd_overdue[NUM_SLOTS_DEF];
	logic [CNT8_W-1:0] wd_mm_cnt;
	logic [SUB_W-1:0]  wd_sub;

	cmd_t cmd_q[$];          // commands waiting for the driver
	rsp_t watchdog_rsp_q[$]; // predicted responses, oldest first

	int n_checked = 0;
	int n_ind     = 0;
	int n_err     = 0;
	int n_phases  = 0;

	function automatic void clear_slot(int s);
		wd_valid[s]   = 1'b0;
		wd_start[s]   = FN_INVALID;
		wd_regfn[s]   = FN_INVALID;
		wd_overdue[s] = '0;
	endfunction

	function automatic void clear_watchdog();
		int s;
		for (s = 0; s < NUM_SLOTS_DEF; s++)
			clear_slot(s);
		wd_mm_cnt = '0;
		wd_sub    = SUB_NULL;
	endfunction

	// registering a release slot drops the matching connect slot; count is kept
	function automatic void take_slot(int s, logic [FN_W-1:0] start, logic [FN_W-1:0] fn);
		wd_start[s] = start;
		wd_regfn[s] = fn;
		wd_valid[s] = 1'b1;
		if (s == SLOT_UL_REL && wd_valid[SLOT_UL_CONN])
			clear_slot(SLOT_UL_CONN);
		if (s == SLOT_DL_REL && wd_valid[SLOT_DL_CONN])
			clear_slot(SLOT_DL_CONN);
	endfunction

	function automatic rsp_t step_watchdog(cmd_t c);
		int unsigned fn, per, base, due, lag;
		int s;
		logic trig;
		rsp_t r;
		fn   = c.frame_number % FRAMES;
		trig = 1'b0;
		case (c.func)
			FN_TICK: begin
				if (wd_sub == SUB_NULL)
					wd_sub = SUB_CHECK;
				per = (wd_period == '0) ? 1 : wd_period;
				if (wd_sub == SUB_CHECK && fn % per == 0) begin
					for (s = 0; s < NUM_SLOTS_DEF; s++) begin
						if (wd_valid[s]) begin
							// connect/low-ts slots age from start frame, releases from registration
							base = (s < SLOT_UL_REL) ? wd_start[s] : wd_regfn[s];
							due  = (base % FRAMES + wd_deadline) % FRAMES;
							lag  = (fn + FRAMES - due) % FRAMES;
							if (lag != 0 && lag < HALF_FRAMES) begin
								if (wd_overdue[s] == wd_ev_trig)
									trig = 1'b1;
								else
									wd_overdue[s] = wd_overdue[s] + 1'b1;
							end
						end
					end
					if (!trig && c.state_mismatch) begin
						if (wd_mm_cnt == wd_mm_trig)
							trig = 1'b1;
						else
							wd_mm_cnt = wd_mm_cnt + 1'b1;
					end else begin
						wd_mm_cnt = '0;
					end
					if (trig)
						wd_sub = SUB_IND_SENT;
				end
			end
			FN_REG_SLOT: begin
				if (!c.blocked_mode && c.event_slot < NUM_SLOTS_DEF)
					take_slot(c.event_slot, c.start_frame, FN_W'(fn));
			end
			FN_DEREG: begin
				if (!c.blocked_mode && c.event_slot < NUM_SLOTS_DEF)
					clear_slot(c.event_slot);
			end
			FN_REG_REL: begin
				if (!c.blocked_mode) begin
					if (c.release_dir[0])
						take_slot(SLOT_UL_REL, FN_INVALID, FN_W'(fn));
					if (c.release_dir[1])
						take_slot(SLOT_DL_REL, FN_INVALID, FN_W'(fn));
				end
			end
			FN_RESET:   clear_watchdog();
			FN_SET_SUB: wd_sub = c.new_substate;
			default: ;
		endcase
		r.recovery_indication = trig;
		r.current_substate    = wd_sub;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Driver: bursts of transfers separated by random gaps
	// ------------------------------------------------------------------
	int burst_left = 1;
	int idle_left  = 0;

	always @(posedge clk) begin
		if (cmd_valid && cmd_ready)
			watchdog_rsp_q.push_back(step_watchdog(cmd));
		if (!cmd_valid || cmd_ready) begin
			if (idle_left != 0) begin
				idle_left--;
				cmd_valid <= 1'b0;
			end else if (cmd_q.size() != 0) begin
				cmd       <= cmd_q.pop_front();
				cmd_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					// a quarter of bursts run back to back; longer gaps span a whole check
					idle_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
				end else begin
					burst_left--;
				end
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: in-order compare; rsp_ready follows random-length runs
	// ------------------------------------------------------------------
	int   ready_run   = 0;
	logic ready_level = 1'b1;
	rsp_t want;

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (watchdog_rsp_q.size() == 0) begin
				n_err++;
				if (n_err <= MAX_REPORTS)
					$display("%0t ERROR: response with none expected: ind=%0b sub=%0d",
						$time, rsp.recovery_indication, rsp.current_substate);
			end else begin
				want = watchdog_rsp_q.pop_front();
				n_checked++;
				if (want.recovery_indication)
					n_ind++;
				if (rsp.recovery_indication !== want.recovery_indication) begin
					n_err++;
					if (n_err <= MAX_REPORTS)
						$display("%0t ERROR: recovery_indication expected %0b, got %0b",
							$time, want.recovery_indication, rsp.recovery_indication);
				end
				if (rsp.current_substate !== want.current_substate) begin
					n_err++;
					if (n_err <= MAX_REPORTS)
						$display("%0t ERROR: current_substate expected %0d, got %0d",
							$time, want.current_substate, rsp.current_substate);
				end
			end
		end
		if (ready_run == 0) begin
			ready_run   = $urandom_range(1, 24);
			ready_level = ($urandom_range(0, 9) < 6);
		end
		ready_run--;
		rsp_ready <= ready_level;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_cmd(logic [FUNC_W-1:0] f, int unsigned fn, logic [SLOT_W-1:0] slot,
		int unsigned start, logic [DIR_W-1:0] dir, logic blk, logic mm, logic [SUB_W-1:0] sub);
		cmd_t c;
		c.func           = f;
		c.frame_number   = FN_W'(fn);
		c.event_slot     = slot;
		c.start_frame    = FN_W'(start);
		c.release_dir    = dir;
		c.blocked_mode   = blk;
		c.state_mismatch = mm;
		c.new_substate   = sub;
		cmd_q.push_back(c);
	endtask

	// register write; predictor copy follows at once since the core is idle
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		case (idx)
			CFG_CHECK_PERIOD: wd_period   = value[PER_W-1:0];
			CFG_DEADLINE:     wd_deadline = value[DL_W-1:0];
			CFG_EV_TRIG:      wd_ev_trig  = value[CNT8_W-1:0];
			CFG_MM_TRIG:      wd_mm_trig  = value[CNT8_W-1:0];
			default: ;
		endcase
	endtask

	// everything sent and answered, then let the core settle
	task automatic wait_idle();
		while (cmd_q.size() != 0 || cmd_valid || watchdog_rsp_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int ph, i, n;
		logic [PER_W-1:0]  p;
		logic [DL_W-1:0]   d;
		logic [CNT8_W-1:0] e, m;
		int unsigned sim_frame, eff, pick, x;
		logic [63:0] raw;
		cmd_t c;
		bit mism_mode;

		clear_watchdog();
		mism_mode = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part at reset register values (period 52, deadline 100, 3, 3)
		push_cmd(FN_TICK, 0, SLOT_UL_CONN, 0, REL_NONE, 0, 0, SUB_NULL);    // null -> check, empty check
		push_cmd(FN_REG_SLOT, 0, SLOT_UL_CONN, 0, REL_NONE, 0, 0, SUB_NULL);
		push_cmd(FN_REG_SLOT, 1, SLOT_DL_CONN, FN_INVALID, REL_NONE, 0, 0, SUB_NULL);
		push_cmd(FN_REG_SLOT, 2, SLOT_LOW_TS, 10, REL_NONE, 0, 0, SUB_NULL);
		push_cmd(FN_REG_SLOT, 3, SLOT_BAD_HI, 5, REL_NONE, 0, 0, SUB_NULL);  // slot out of range
		push_cmd(FN_REG_SLOT, 3, SLOT_DL_REL, 5, REL_NONE, 1, 0, SUB_NULL);  // blocked
		push_cmd(FN_REG_REL, 5, SLOT_UL_CONN, 0, REL_UL, 0, 0, SUB_NULL);    // drops ul connect
		push_cmd(FN_REG_REL, 6, SLOT_UL_CONN, 0, REL_NONE, 0, 0, SUB_NULL);  // no direction
		push_cmd(FN_REG_REL, 7, SLOT_UL_CONN, 0, REL_BOTH, 1, 0, SUB_NULL);  // blocked
		push_cmd(FN_DEREG, 8, SLOT_LOW_TS, 0, REL_NONE, 1, 0, SUB_NULL);     // blocked
		push_cmd(FN_DEREG, 8, SLOT_BAD_LO, 0, REL_NONE, 0, 0, SUB_NULL);     // slot out of range
		push_cmd(FN_TICK, 100, SLOT_UL_CONN, 0, REL_NONE, 0, 1, SUB_NULL);   // not a check frame
		for (i = 3; i <= 7; i++)                                            // overdue counting to trigger
			push_cmd(FN_TICK, 52 * i, SLOT_UL_CONN, 0, REL_NONE, 0, 1, SUB_NULL);
		push_cmd(FN_SET_SUB, 0, SLOT_UL_CONN, 0, REL_NONE, 0, 0, SUB_STARTED);
		push_cmd(FN_TICK, 416, SLOT_UL_CONN, 0, REL_NONE, 0, 1, SUB_NULL);   // started: no check
		push_cmd(FN_SET_SUB, 0, SLOT_UL_CONN, 0, REL_NONE, 0, 0, SUB_NULL);
		push_cmd(FN_TICK, FRAMES + 52, SLOT_UL_CONN, 0, REL_NONE, 0, 1, SUB_NULL); // frame wraps
		push_cmd(FUNC_SPARE_6, FN_INVALID, SLOT_BAD_HI, FN_INVALID, REL_BOTH, 1, 1, SUB_STARTED);
		push_cmd(FUNC_SPARE_7, 0, SLOT_UL_CONN, 0, REL_NONE, 0, 0, SUB_NULL);
		push_cmd(FN_RESET, 0, SLOT_UL_CONN, 0, REL_NONE, 0, 0, SUB_NULL);
		push_cmd(FN_TICK, FRAMES - 1, SLOT_UL_CONN, 0, REL_NONE, 0, 0, SUB_NULL);
		push_cmd(FN_TICK, FN_INVALID, SLOT_UL_CONN, 0, REL_NONE, 0, 1, SUB_NULL);
		push_cmd(FN_REG_REL, FRAMES - 1, SLOT_UL_CONN, 0, REL_BOTH, 0, 0, SUB_NULL);
		push_cmd(FN_REG_REL, FN_INVALID, SLOT_UL_CONN, 0, REL_DL, 0, 0, SUB_NULL);
		push_cmd(FN_DEREG, 0, SLOT_DL_REL, 0, REL_NONE, 0, 0, SUB_NULL);
		wait_idle();

		// random phases: extremes first, then random register settings
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			n = 200;
			case (ph)
				0: begin p = 8'd1;   d = 16'd0;     e = 8'd0;   m = 8'd0;   end
				1: begin p = 8'd255; d = 16'hFFFF;  e = 8'd255; m = 8'd255; n = 120; end
				2: begin p = 8'd0;   d = 16'd50;    e = 8'd1;   m = 8'd1;   end  // zero period
				default: begin
					p = $urandom_range(1, 16);
					d = $urandom_range(0, 400);
					e = $urandom_range(0, 5);
					m = $urandom_range(0, 5);
				end
			endcase
			// junk in the upper byte of the narrow registers must be dropped
			write_reg(CFG_CHECK_PERIOD, {8'($urandom_range(0, 255)), p});
			write_reg(CFG_DEADLINE, d);
			write_reg(CFG_EV_TRIG, {8'($urandom_range(0, 255)), e});
			write_reg(CFG_MM_TRIG, {8'($urandom_range(0, 255)), m});
			@(posedge clk);
			cfg_we <= 1'b0;
			@(negedge clk);
			n_phases++;

			eff = (p == '0) ? 1 : p;
			case ($urandom_range(0, 3))
				0:       sim_frame = 0;
				1:       sim_frame = FRAMES - $urandom_range(1, 2000);  // cross the wrap
				default: sim_frame = $urandom_range(0, FRAMES - 1);
			endcase

			for (i = 0; i < n; i++) begin
				// start from noise so every field bit toggles
				raw = {$urandom, $urandom};
				c   = raw[$bits(cmd_t)-1:0];
				if ($urandom_range(0, 99) >= 8) begin
					// well-formed command around a running frame counter
					c.blocked_mode = ($urandom_range(0, 9) == 0);
					if ($urandom_range(0, 6) == 0)
						mism_mode = !mism_mode;
					c.state_mismatch = mism_mode;
					pick = $urandom_range(0, 99);
					if (pick < 55) begin
						c.func = FN_TICK;
						if ($urandom_range(0, 3) != 0)
							sim_frame = (sim_frame / eff + 1) * eff;  // next check frame
						else
							sim_frame = sim_frame + $urandom_range(1, 2 * eff);
						sim_frame = sim_frame % FRAMES;
						if (sim_frame < FN_SPAN - FRAMES && $urandom_range(0, 9) == 0)
							c.frame_number = FN_W'(sim_frame + FRAMES);
						else
							c.frame_number = FN_W'(sim_frame);
					end else begin
						c.frame_number = FN_W'(sim_frame);
						if (pick < 72) begin
							c.func       = FN_REG_SLOT;
							c.event_slot = $urandom_range(0, NUM_SLOTS_DEF - 1);
							case ($urandom_range(0, 9))
								0, 1, 2, 3, 4: begin  // recent: goes overdue soon
									x = $urandom_range(0, 3 * eff + d);
									c.start_frame = FN_W'((sim_frame + FRAMES - x % FRAMES) % FRAMES);
								end
								5, 6: begin           // long past: overdue at once
									x = $urandom_range(0, HALF_FRAMES);
									c.start_frame = FN_W'((sim_frame + FRAMES - x) % FRAMES);
								end
								7: c.start_frame = FN_W'((sim_frame + $urandom_range(0, 500)) % FRAMES);
								default: ;            // keep the noise value
							endcase
						end else if (pick < 82) begin
							c.func        = FN_REG_REL;
							c.release_dir = $urandom_range(1, 3);
						end else if (pick < 90) begin
							c.func       = FN_DEREG;
							c.event_slot = $urandom_range(0, NUM_SLOTS_DEF - 1);
						end else if (pick < 92) begin
							c.func = FN_RESET;
						end else begin
							c.func = FN_SET_SUB;
						end
					end
				end
				cmd_q.push_back(c);
			end
			wait_idle();
		end

		$display("Run covered %0d responses over %0d register settings plus directed cases;",
			n_checked, n_phases);
		$display("%0d of them carried a recovery indication, %0d mismatches.", n_ind, n_err);
		if (n_err == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog on the bench itself
	initial begin
		#10_000_000;
		$display("Timeout: stimulus or responses stalled.");
		$display("*** FAILED ***");
		$finish;
	end

endmodule
